>>> rtl/glh_pkg.sv
// Package for the gray level histogram: sizes, command codes and item types.
`default_nettype none

package glh_pkg;

  localparam int unsigned BinCount   = 256;
  localparam int unsigned CountWidth = 24;
  localparam int unsigned IdxW       = (BinCount > 1) ? $clog2(BinCount) : 1;
  localparam int unsigned PixelW     = 8;
  localparam int unsigned FieldW     = 24;

  typedef enum logic [1:0] {
    CmdCount = 2'd0,
    CmdRead  = 2'd1,
    CmdClear = 2'd2
  } glh_cmd_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [PixelW-1:0] pixel_value;
  } glh_in_t;

  typedef struct packed {
    logic [FieldW-1:0] bin_count;
    logic [FieldW-1:0] peak_count;
  } glh_out_t;

endpackage

`default_nettype wire

>>> rtl/gray_level_histogram_top.sv
// Gray level histogram: bin store with read-modify-write and a running peak.
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+-----------------------------------
//  item in  | start, busy, item_i        | taken at edge with start && !busy
//  result   | strobe_o, result_o         | valid for one cycle, no stall
//
// One item per cycle, sustained, for any mix of count, read and clear items.
// The result strobes after the item is taken: first the registered read of
// the bin memory, then the update and write-back with the result registered.
// An item right behind a count on the same bin gets the written value
// forwarded. A clear drops the per-bin valid bits at once.
// After reset, busy stays high for one cycle; the receiver cannot stall.
`default_nettype none

module gray_level_histogram_top
  import glh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire glh_in_t  item_i,
  output logic          busy,
  output logic          strobe_o,
  output glh_out_t      result_o
);

  localparam logic [CountWidth-1:0] CountTop = {CountWidth{1'b1}};

  // Bin store: payload in memory, valid bits in flops (invalid reads as zero).
  logic [CountWidth-1:0] mem [BinCount];
  logic [BinCount-1:0]   valid_q, valid_d;

  logic busy_q;

  // Stage 1: item waiting for its memory read data.
  logic                  s1_vld_q;
  logic [1:0]            s1_cmd_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic                  s1_inr_q;
  logic [CountWidth-1:0] rd_q;
  logic                  vbit_q, vbit_d;
  logic                  fwd_q;
  logic [CountWidth-1:0] fwd_data_q;

  logic [CountWidth-1:0] peak_q, peak_d;

  logic                  strobe_q;
  glh_out_t              result_q, result_d;

  logic                  accept;
  logic [IdxW-1:0]       acc_idx;
  logic                  acc_inr;

  logic                  wr_en;
  logic [CountWidth-1:0] cur, nxt;
  logic                  clr_now;

  assign accept  = start && !busy_q;
  assign acc_idx = IdxW'(item_i.pixel_value);
  assign acc_inr = (32'(item_i.pixel_value) < 32'(BinCount));

  // Current bin value: forwarded write-back, memory data, or zero if cleared.
  assign cur = fwd_q ? fwd_data_q : (vbit_q ? rd_q : '0);
  assign nxt = (cur == CountTop) ? cur : cur + 1'b1;

  always_comb begin
    wr_en    = 1'b0;
    clr_now  = 1'b0;
    peak_d   = peak_q;
    valid_d  = valid_q;
    result_d = '0;
    if (s1_vld_q) begin
      case (s1_cmd_q)
        CmdCount: begin
          if (s1_inr_q) begin
            wr_en             = 1'b1;
            valid_d[s1_idx_q] = 1'b1;
            if (nxt > peak_q) begin
              peak_d = nxt;
            end
            result_d.bin_count = FieldW'(nxt);
          end
          result_d.peak_count = (s1_inr_q && nxt > peak_q) ? FieldW'(nxt) : FieldW'(peak_q);
        end
        CmdClear: begin
          clr_now  = 1'b1;
          valid_d  = '0;
          peak_d   = '0;
        end
        default: begin
          // read, and the unused code that behaves as a read
          result_d.bin_count  = s1_inr_q ? FieldW'(cur) : '0;
          result_d.peak_count = FieldW'(peak_q);
        end
      endcase
    end
  end

  // Valid bit seen by the item taken this edge, after this edge's update.
  always_comb begin
    if (clr_now) begin
      vbit_d = 1'b0;
    end else if (wr_en && (s1_idx_q == acc_idx)) begin
      vbit_d = 1'b1;
    end else begin
      vbit_d = valid_q[acc_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_idx_q] <= nxt;
    end
    if (accept) begin
      rd_q <= mem[acc_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= item_i.command;
      s1_idx_q   <= acc_idx;
      s1_inr_q   <= acc_inr;
      vbit_q     <= vbit_d;
      fwd_q      <= !clr_now && wr_en && (s1_idx_q == acc_idx);
      fwd_data_q <= nxt;
    end
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      s1_vld_q <= 1'b0;
      strobe_q <= 1'b0;
      valid_q  <= '0;
      peak_q   <= '0;
    end else begin
      busy_q   <= 1'b0;
      s1_vld_q <= accept;
      strobe_q <= s1_vld_q;
      valid_q  <= valid_d;
      peak_q   <= peak_d;
    end
  end

  assign busy     = busy_q;
  assign strobe_o = strobe_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

>>> rtl/glh_checker.sv
// Port-level checker for the gray level histogram, bound to the top level.
`default_nettype none

module glh_checker
  import glh_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire glh_in_t  item_i,
  input wire logic     busy,
  input wire logic     strobe_o,
  input wire glh_out_t result_o
);

  // every item taken gives its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 strobe_o)
    else $error("result missing two cycles after item");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, 2))
    else $error("result without item");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CmdClear) |=> ##1
      (result_o.bin_count == '0 && result_o.peak_count == '0))
    else $error("clear result not zero");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (result_o.bin_count <= result_o.peak_count))
    else $error("bin count above peak");

  a_peak_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && $past(strobe_o) && $past(item_i.command, 2) != CmdClear) |->
      (result_o.peak_count >= $past(result_o.peak_count)))
    else $error("peak dropped without clear");

endmodule

bind gray_level_histogram_top glh_checker u_glh_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .item_i   (item_i),
  .busy     (busy),
  .strobe_o (strobe_o),
  .result_o (result_o)
);

`default_nettype wire
